// File: src/touch_tap_swipe_classifier_core_assert.svh
// Assertion macros for the tap/swipe classifier checker.
`ifndef TOUCH_TAP_SWIPE_CLASSIFIER_CORE_ASSERT_SVH
`define TOUCH_TAP_SWIPE_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, masked while the reset is high.
`define TTSC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ttsc: implication check failed");

// Next-cycle implication, masked while the reset is high.
`define TTSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ttsc: next-cycle check failed");

`endif

// File: src/ttsc_pkg.sv
// Shared types, constants and width helpers for the tap/swipe classifier.
package ttsc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int THR_BITS       = 12;
  localparam int HOLD_BITS      = 16;
  localparam int TIME_BITS      = 32;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SWIPE_MIN    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_MARGIN  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP_MAX_MOVE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP_MIN_HOLD = 3'd4;

  localparam logic [THR_BITS-1:0]  SWIPE_MIN_RST    = 12'd40;
  localparam logic [THR_BITS-1:0]  AXIS_MARGIN_RST  = 12'd8;
  localparam logic [THR_BITS-1:0]  TAP_MAX_MOVE_RST = 12'd16;
  localparam logic [HOLD_BITS-1:0] TAP_MIN_HOLD_RST = 16'd12;

  localparam logic signed [1:0] DIR_NONE = 2'sb00;
  localparam logic signed [1:0] DIR_POS  = 2'sb01;
  localparam logic signed [1:0] DIR_NEG  = 2'sb11;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_TAP   = 2'd1,
    EV_SWIPE = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic                 enable;
    logic [THR_BITS-1:0]  swipe_min_distance;
    logic [THR_BITS-1:0]  axis_margin;
    logic [THR_BITS-1:0]  tap_max_move;
    logic [HOLD_BITS-1:0] tap_min_hold_ms;
  } cfg_t;

  // Stream widths, rounded up to whole bytes.
  function automatic int in_data_bits(input int cb);
    return ((2 * cb + TIME_BITS + 7) / 8) * 8;
  endfunction

  function automatic int out_data_bits(input int cb);
    return ((4 * cb + 6 + 7) / 8) * 8;
  endfunction

endpackage

// File: src/ttsc_cfg_regs.sv
// Configuration register file for the tap/swipe classifier.
module ttsc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ttsc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [ttsc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output ttsc_pkg::cfg_t                     cfg
);
  import ttsc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable             <= 1'b0;
      cfg.swipe_min_distance <= SWIPE_MIN_RST;
      cfg.axis_margin        <= AXIS_MARGIN_RST;
      cfg.tap_max_move       <= TAP_MAX_MOVE_RST;
      cfg.tap_min_hold_ms    <= TAP_MIN_HOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:       cfg.enable             <= cfg_data[0];
        REG_SWIPE_MIN:    cfg.swipe_min_distance <= cfg_data[THR_BITS-1:0];
        REG_AXIS_MARGIN:  cfg.axis_margin        <= cfg_data[THR_BITS-1:0];
        REG_TAP_MAX_MOVE: cfg.tap_max_move       <= cfg_data[THR_BITS-1:0];
        REG_TAP_MIN_HOLD: cfg.tap_min_hold_ms    <= cfg_data[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/ttsc_classify.sv
// Press state and single-pass gesture classification for one poll.
module ttsc_classify #(
  parameter int COORD_BITS = ttsc_pkg::COORD_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  ttsc_pkg::cfg_t                                 cfg,
  input  logic                                           fire,
  input  logic                                           touched,
  input  logic [COORD_BITS-1:0]                          touch_x,
  input  logic [COORD_BITS-1:0]                          touch_y,
  input  logic [ttsc_pkg::TIME_BITS-1:0]                 now_ms,
  output ttsc_pkg::event_kind_t                          kind,
  output logic [ttsc_pkg::out_data_bits(COORD_BITS)-1:0] res_data
);
  import ttsc_pkg::*;

  localparam int OUT_BITS = out_data_bits(COORD_BITS);
  localparam int CW       = (COORD_BITS > THR_BITS) ? COORD_BITS : THR_BITS;
  localparam int SW       = CW + 1;

  logic                  pressed, pressed_next;
  logic                  swipe_latch, swipe_latch_next;
  logic                  live_flag, live_flag_next;
  logic [COORD_BITS-1:0] start_x, start_x_next, start_y, start_y_next;
  logic [COORD_BITS-1:0] last_x, last_x_next, last_y, last_y_next;
  logic [TIME_BITS-1:0]  press_time, press_time_next;

  logic [COORD_BITS-1:0] ax, ay, sx, sy, adx, ady;
  logic [SW-1:0]         adx_w, ady_w, smd_w, mg_w, tmm_w;
  logic [TIME_BITS-1:0]  held_ms;
  logic                  new_press, x_far, y_far, x_swipe, y_swipe, tap_ok;
  logic [COORD_BITS-1:0] tap_x, tap_y;
  logic signed [1:0]     sdx, sdy;

  // One pair of subtractors serves both the live latch test and the release test.
  assign new_press = touched && !pressed;
  assign ax  = touched ? touch_x : last_x;
  assign ay  = touched ? touch_y : last_y;
  assign sx  = new_press ? touch_x : start_x;
  assign sy  = new_press ? touch_y : start_y;
  assign adx = (ax >= sx) ? ax - sx : sx - ax;
  assign ady = (ay >= sy) ? ay - sy : sy - ay;

  assign adx_w = SW'(adx);
  assign ady_w = SW'(ady);
  assign smd_w = SW'(cfg.swipe_min_distance);
  assign mg_w  = SW'(cfg.axis_margin);
  assign tmm_w = SW'(cfg.tap_max_move);

  assign x_far   = adx_w >= smd_w;
  assign y_far   = ady_w >= smd_w;
  assign x_swipe = x_far && (adx_w > ady_w + mg_w);
  assign y_swipe = y_far && (ady_w > adx_w + mg_w);
  assign held_ms = now_ms - press_time;
  assign tap_ok  = (held_ms >= TIME_BITS'(cfg.tap_min_hold_ms)) &&
                   (adx_w <= tmm_w) && (ady_w <= tmm_w);

  always_comb begin
    pressed_next     = pressed;
    swipe_latch_next = swipe_latch;
    live_flag_next   = live_flag;
    start_x_next     = start_x;
    start_y_next     = start_y;
    last_x_next      = last_x;
    last_y_next      = last_y;
    press_time_next  = press_time;
    kind             = EV_NONE;
    tap_x            = '0;
    tap_y            = '0;
    sdx              = DIR_NONE;
    sdy              = DIR_NONE;
    if (cfg.enable) begin
      if (touched) begin
        last_x_next    = touch_x;
        last_y_next    = touch_y;
        live_flag_next = 1'b1;
        pressed_next   = 1'b1;
        start_x_next   = sx;
        start_y_next   = sy;
        if (new_press) begin
          press_time_next = now_ms;
        end
        // a fresh press starts with the latch clear
        swipe_latch_next = (swipe_latch && !new_press) || (x_far && (adx > ady));
      end else begin
        live_flag_next = 1'b0;
        if (pressed) begin
          pressed_next     = 1'b0;
          swipe_latch_next = 1'b0;
          priority if (x_swipe) begin
            kind = EV_SWIPE;
            sdx  = (last_x < start_x) ? DIR_NEG : DIR_POS;
          end else if (y_swipe) begin
            kind = EV_SWIPE;
            sdy  = (last_y < start_y) ? DIR_NEG : DIR_POS;
          end else if (tap_ok) begin
            kind  = EV_TAP;
            tap_x = last_x;
            tap_y = last_y;
          end else begin
            // ambiguous release
            kind = EV_NONE;
          end
        end
      end
    end
  end

  assign res_data = OUT_BITS'({swipe_latch_next, last_y_next, last_x_next, live_flag_next,
                               sdy, sdx, tap_y, tap_x});

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed     <= 1'b0;
      swipe_latch <= 1'b0;
      live_flag   <= 1'b0;
      start_x     <= '0;
      start_y     <= '0;
      last_x      <= '0;
      last_y      <= '0;
      press_time  <= '0;
    end else if (fire) begin
      pressed     <= pressed_next;
      swipe_latch <= swipe_latch_next;
      live_flag   <= live_flag_next;
      start_x     <= start_x_next;
      start_y     <= start_y_next;
      last_x      <= last_x_next;
      last_y      <= last_y_next;
      press_time  <= press_time_next;
    end
  end

endmodule

// File: src/touch_tap_swipe_classifier_core.sv
// Touch tap/swipe classifier: an input beat passes the input register, then the
// result register, before it leaves as a result beat. One poll accepted per cycle
// while m_tready holds, with one result per poll; the press-state update and
// classification sit in a single pass between the two registers. A stalled result
// register holds the input register, which then holds s_tready low. Reset empties
// both registers, clears the press state and restores the configuration defaults.
module touch_tap_swipe_classifier_core #(
  parameter int COORD_BITS = ttsc_pkg::COORD_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           s_tvalid,
  output logic                                           s_tready,
  // touch_x, touch_y, now_ms
  input  logic [ttsc_pkg::in_data_bits(COORD_BITS)-1:0]  s_tdata,
  // touched
  input  logic                                           s_tuser,
  output logic                                           m_tvalid,
  input  logic                                           m_tready,
  // tap_x, tap_y, swipe_dir_x, swipe_dir_y, live, point_x, point_y, swiping
  output logic [ttsc_pkg::out_data_bits(COORD_BITS)-1:0] m_tdata,
  // event_kind
  output ttsc_pkg::event_kind_t                          m_tuser,
  input  logic                                           cfg_valid,
  output logic                                           cfg_ready,
  input  logic [ttsc_pkg::CFG_IDX_BITS-1:0]              cfg_index,
  input  logic [ttsc_pkg::CFG_DATA_BITS-1:0]             cfg_data
);
  import ttsc_pkg::*;

  localparam int OUT_BITS = out_data_bits(COORD_BITS);

  cfg_t                  cfg;
  logic                  in_valid;
  logic                  in_touched;
  logic [COORD_BITS-1:0] in_x, in_y;
  logic [TIME_BITS-1:0]  in_now;
  logic                  s_fire, advance;
  event_kind_t           kind;
  logic [OUT_BITS-1:0]   res_data;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_fire   = s_tvalid && s_tready;

  ttsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ttsc_classify #(
    .COORD_BITS (COORD_BITS)
  ) u_classify (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .fire     (advance),
    .touched  (in_touched),
    .touch_x  (in_x),
    .touch_y  (in_y),
    .now_ms   (in_now),
    .kind     (kind),
    .res_data (res_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_fire) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_touched <= s_tuser;
      in_x       <= s_tdata[COORD_BITS-1:0];
      in_y       <= s_tdata[2*COORD_BITS-1:COORD_BITS];
      in_now     <= s_tdata[2*COORD_BITS+TIME_BITS-1:2*COORD_BITS];
    end
    if (advance) begin
      m_tdata <= res_data;
      m_tuser <= kind;
    end
  end

endmodule

// File: src/ttsc_checker.sv
// Port-level checker for the tap/swipe classifier, bound to the top level.
`include "touch_tap_swipe_classifier_core_assert.svh"

module ttsc_checker #(
  parameter int COORD_BITS = ttsc_pkg::COORD_BITS_DEF
) (
  input logic                                           clk,
  input logic                                           rst,
  input logic                                           m_tvalid,
  input logic                                           m_tready,
  input logic [ttsc_pkg::out_data_bits(COORD_BITS)-1:0] m_tdata,
  input ttsc_pkg::event_kind_t                          m_tuser
);
  import ttsc_pkg::*;

  localparam int C = COORD_BITS;

  logic [C-1:0]      tap_x, tap_y, point_x, point_y;
  logic signed [1:0] sdx, sdy;
  logic              live;

  assign tap_x   = m_tdata[C-1:0];
  assign tap_y   = m_tdata[2*C-1:C];
  assign sdx     = m_tdata[2*C+1:2*C];
  assign sdy     = m_tdata[2*C+3:2*C+2];
  assign live    = m_tdata[2*C+4];
  assign point_x = m_tdata[3*C+4:2*C+5];
  assign point_y = m_tdata[4*C+4:3*C+5];

  `TTSC_ASSERT_NEXT(a_rst_empties, clk, 1'b0, rst, !m_tvalid)
  `TTSC_ASSERT_NEXT(a_stall_holds, clk, rst, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `TTSC_ASSERT_IMPLY(a_tap_at_release, clk, rst, m_tvalid && (m_tuser == EV_TAP),
                     !live && (tap_x == point_x) && (tap_y == point_y) &&
                     (sdx == DIR_NONE) && (sdy == DIR_NONE))
  `TTSC_ASSERT_IMPLY(a_swipe_one_axis, clk, rst, m_tvalid && (m_tuser == EV_SWIPE),
                     !live && ((sdx != DIR_NONE) != (sdy != DIR_NONE)) &&
                     (tap_x == '0) && (tap_y == '0))
  `TTSC_ASSERT_IMPLY(a_none_is_quiet, clk, rst, m_tvalid && (m_tuser == EV_NONE),
                     (sdx == DIR_NONE) && (sdy == DIR_NONE) &&
                     (tap_x == '0) && (tap_y == '0))

endmodule

bind touch_tap_swipe_classifier_core ttsc_checker #(
  .COORD_BITS (COORD_BITS)
) u_ttsc_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser)
);
